### rtl/core/tksl_pkg.sv
package tksl_pkg;

    localparam int K_ENTRIES = 16;
    localparam int LIST_LEN  = K_ENTRIES + 1;
    localparam int IDX_W     = $clog2(LIST_LEN);
    localparam int CNT_W     = $clog2(LIST_LEN + 1);

    localparam int SCORE_W = 18;
    localparam int REF_W   = 32;
    localparam int LEN_W   = 48;
    localparam int RANK_W  = 5;

    localparam logic [SCORE_W-1:0] ONE_Q16   = SCORE_W'(65536);
    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(LIST_LEN - 1);
    localparam logic [CNT_W-1:0]   FULL_CNT  = CNT_W'(LIST_LEN);

    localparam logic REQ_OFFER = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [REF_W-1:0]   ref_id;
        logic [LEN_W-1:0]   seq_length;
    } entry_t;

    localparam entry_t RESET_ENTRY = '{
        score:      ONE_Q16,
        ref_id:     '0,
        seq_length: LEN_W'(1)
    };

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
    } mem_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_STEP,
        S_CMP,
        S_RDOUT
    } state_t;

endpackage

### rtl/core/tksl_list_mem.sv
module tksl_list_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  tksl_pkg::mem_ctl_t ctl,
    input  tksl_pkg::entry_t   wr_data,
    output tksl_pkg::entry_t   rd_data
);
    import tksl_pkg::*;

    entry_t              mem [LIST_LEN];
    logic [LIST_LEN-1:0] valid_reg;
    entry_t              rd_q_reg;
    logic                rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_q_reg <= mem[ctl.rd_addr];
        end
    end

    // slot never written reads as its reset contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[ctl.wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_vld_reg <= valid_reg[ctl.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : RESET_ENTRY;

endmodule

### rtl/core/tksl_seq.sv
module tksl_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          req_type,
    input  logic [tksl_pkg::SCORE_W-1:0]  score,
    input  logic [tksl_pkg::REF_W-1:0]    ref_id,
    input  logic [tksl_pkg::LEN_W-1:0]    seq_length,
    input  logic [tksl_pkg::RANK_W-1:0]   rank,
    output logic                          busy,
    output tksl_pkg::mem_ctl_t            mem_ctl,
    output tksl_pkg::entry_t              mem_wr_data,
    input  tksl_pkg::entry_t              mem_rd_data,
    output logic                          done,
    output logic                          accepted,
    output logic [tksl_pkg::RANK_W-1:0]   placed_rank,
    output logic [tksl_pkg::SCORE_W-1:0]  entry_score,
    output logic [tksl_pkg::REF_W-1:0]    entry_ref_id,
    output logic [tksl_pkg::LEN_W-1:0]    entry_length,
    output logic [tksl_pkg::RANK_W-1:0]   filled
);
    import tksl_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    entry_t             cand_reg, cand_next;
    logic [RANK_W-1:0]  rank_reg, rank_next;

    logic               done_reg, done_next;
    logic               acc_reg, acc_next;
    logic [RANK_W-1:0]  prank_reg, prank_next;
    entry_t             out_reg, out_next;

    logic               cand_lt;

    // the shared comparator: candidate against the entry just read
    assign cand_lt = cand_reg.score < mem_rd_data.score;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            acc_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        cand_reg  <= cand_next;
        rank_reg  <= rank_next;
        prank_reg <= prank_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        cand_next   = cand_reg;
        rank_next   = rank_reg;
        done_next   = 1'b0;
        acc_next    = 1'b0;
        prank_next  = prank_reg;
        out_next    = out_reg;
        mem_ctl     = '0;
        mem_wr_data = cand_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cand_next = '{score: score, ref_id: ref_id, seq_length: seq_length};
                    rank_next = rank;
                    if (req_type == REQ_READ)
                    begin
                        if (int'(rank) < LIST_LEN)
                        begin
                            mem_ctl.rd_en   = 1'b1;
                            mem_ctl.rd_addr = IDX_W'(rank);
                            state_next      = S_RDOUT;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            prank_next = rank;
                            out_next   = '0;
                        end
                    end
                    else if (count_reg < FULL_CNT)
                    begin
                        pos_next   = IDX_W'(count_reg);
                        count_next = CNT_W'(count_reg + 1'b1);
                        state_next = S_STEP;
                    end
                    else
                    begin
                        mem_ctl.rd_en   = 1'b1;
                        mem_ctl.rd_addr = LAST_IDX;
                        state_next      = S_CHK;
                    end
                end
            end

            S_CHK:
            begin
                if (cand_lt)
                begin
                    pos_next   = LAST_IDX;
                    state_next = S_STEP;
                end
                else
                begin
                    done_next  = 1'b1;
                    prank_next = '0;
                    out_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_STEP:
            begin
                if (pos_reg == '0)
                begin
                    mem_ctl.wr_en   = 1'b1;
                    mem_ctl.wr_addr = '0;
                    done_next       = 1'b1;
                    acc_next        = 1'b1;
                    prank_next      = '0;
                    out_next        = '0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    mem_ctl.rd_en   = 1'b1;
                    mem_ctl.rd_addr = pos_reg - 1'b1;
                    state_next      = S_CMP;
                end
            end

            S_CMP:
            begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_addr = pos_reg;
                if (cand_lt)
                begin
                    // entry above is worse: move it down one slot
                    mem_wr_data = mem_rd_data;
                    pos_next    = pos_reg - 1'b1;
                    state_next  = S_STEP;
                end
                else
                begin
                    // equal scores stay ahead of the newcomer
                    done_next  = 1'b1;
                    acc_next   = 1'b1;
                    prank_next = RANK_W'(pos_reg);
                    out_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_RDOUT:
            begin
                done_next  = 1'b1;
                prank_next = rank_reg;
                out_next   = mem_rd_data;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign accepted     = acc_reg;
    assign placed_rank  = prank_reg;
    assign entry_score  = out_reg.score;
    assign entry_ref_id = out_reg.ref_id;
    assign entry_length = out_reg.seq_length;
    assign filled       = RANK_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("offer count beyond list length");

    a_acc_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg |-> done_reg)
        else $error("accepted without result strobe");

    a_done_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) != S_IDLE) || $past(start))
        else $error("result word without a request");

    a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.wr_en |-> busy && (mem_ctl.wr_addr <= LAST_IDX))
        else $error("list write while idle or out of range");

    a_shift_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) && cand_lt |=> (state_reg == S_STEP)
            && (pos_reg == $past(pos_reg) - 1'b1))
        else $error("insertion walk lost its place");

endmodule

### rtl/core/top_k_smallest_score_list.sv
// Keeps the LIST_LEN (K_ENTRIES + 1) candidates with the smallest Q2.16 scores in
// ascending order; among equal scores earlier arrivals stay ahead. A request is
// taken when start is high and busy is low. Results come as a one-cycle word
// marked by done and must be captured on that cycle. One comparator and a list
// memory with separate read and write ports do the work, walking up from the
// tail one slot at a time: each slot shifted takes a read of the slot above
// (S_STEP) and a compare and write (S_CMP). An offer to an already full list
// first checks the tail; a full-list offer that is rejected ends there. A rank
// read does one memory read; a rank past the list answers with zeros and no busy
// at all. done is high in the first cycle with busy low again (or the cycle after
// the request for an out-of-range rank), so a new request can be taken in that same cycle.
module top_k_smallest_score_list (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          req_type,
    input  logic [tksl_pkg::SCORE_W-1:0]  score,
    input  logic [tksl_pkg::REF_W-1:0]    ref_id,
    input  logic [tksl_pkg::LEN_W-1:0]    seq_length,
    input  logic [tksl_pkg::RANK_W-1:0]   rank,
    output logic                          done,
    output logic                          accepted,
    output logic [tksl_pkg::RANK_W-1:0]   placed_rank,
    output logic [tksl_pkg::SCORE_W-1:0]  entry_score,
    output logic [tksl_pkg::REF_W-1:0]    entry_ref_id,
    output logic [tksl_pkg::LEN_W-1:0]    entry_length,
    output logic [tksl_pkg::RANK_W-1:0]   filled
);
    import tksl_pkg::*;

    mem_ctl_t mem_ctl;
    entry_t   mem_wr_data;
    entry_t   mem_rd_data;

    tksl_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req_type     (req_type),
        .score        (score),
        .ref_id       (ref_id),
        .seq_length   (seq_length),
        .rank         (rank),
        .busy         (busy),
        .mem_ctl      (mem_ctl),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_data  (mem_rd_data),
        .done         (done),
        .accepted     (accepted),
        .placed_rank  (placed_rank),
        .entry_score  (entry_score),
        .entry_ref_id (entry_ref_id),
        .entry_length (entry_length),
        .filled       (filled)
    );

    tksl_list_mem u_list_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

endmodule

### bench/top_k_smallest_score_list_tb.sv
`timescale 1ns / 1ps

module top_k_smallest_score_list_tb;

    import tksl_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct packed {
        logic               accepted;
        logic [RANK_W-1:0]  placed_rank;
        logic [SCORE_W-1:0] entry_score;
        logic [REF_W-1:0]   entry_ref_id;
        logic [LEN_W-1:0]   entry_length;
        logic [RANK_W-1:0]  filled;
    } list_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               req_type = REQ_OFFER;
    logic [SCORE_W-1:0] score = '0;
    logic [REF_W-1:0]   ref_id = '0;
    logic [LEN_W-1:0]   seq_length = '0;
    logic [RANK_W-1:0]  rank = '0;
    logic               done;
    logic               accepted;
    logic [RANK_W-1:0]  placed_rank;
    logic [SCORE_W-1:0] entry_score;
    logic [REF_W-1:0]   entry_ref_id;
    logic [LEN_W-1:0]   entry_length;
    logic [RANK_W-1:0]  filled;

    // predicted list contents
    logic [SCORE_W-1:0] held_score [LIST_LEN];
    logic [REF_W-1:0]   held_ref   [LIST_LEN];
    logic [LEN_W-1:0]   held_len   [LIST_LEN];
    int                 held_count;

    list_word_t expected_words [$];

    int  mismatch_count = 0;
    int  words_checked  = 0;
    int  offers_sent    = 0;
    int  offers_entered = 0;
    int  reads_sent     = 0;
    int  idle_cycles    = 0;
    int  burst_left     = 1;
    bit  gaps_on        = 1'b1;

    top_k_smallest_score_list i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .score        (score),
        .ref_id       (ref_id),
        .seq_length   (seq_length),
        .rank         (rank),
        .done         (done),
        .accepted     (accepted),
        .placed_rank  (placed_rank),
        .entry_score  (entry_score),
        .entry_ref_id (entry_ref_id),
        .entry_length (entry_length),
        .filled       (filled)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_list();
        for (int i = 0; i < LIST_LEN; i++)
        begin
            held_score[i] = ONE_Q16;
            held_ref[i]   = '0;
            held_len[i]   = LEN_W'(1);
        end
        held_count = 0;
    endfunction

    // Stable insertion: a new candidate lands behind all equal scores.
    function automatic list_word_t apply_request(input logic rq, input logic [SCORE_W-1:0] sc,
                                                 input logic [REF_W-1:0] rf,
                                                 input logic [LEN_W-1:0] ln,
                                                 input logic [RANK_W-1:0] rk);
        list_word_t w;
        int         used;
        int         pos;
        bit         do_insert;
        w         = '0;
        used      = 0;
        pos       = 0;
        do_insert = 1'b0;
        if (rq == REQ_OFFER)
        begin
            if (held_count < LIST_LEN)
            begin
                used       = held_count;
                held_count = held_count + 1;
                do_insert  = 1'b1;
            end
            else if (sc < held_score[LIST_LEN-1])
            begin
                used      = LIST_LEN - 1;
                do_insert = 1'b1;
            end
            if (do_insert)
            begin
                while (pos < used && held_score[pos] <= sc)
                    pos++;
                for (int i = used; i > pos; i--)
                begin
                    held_score[i] = held_score[i-1];
                    held_ref[i]   = held_ref[i-1];
                    held_len[i]   = held_len[i-1];
                end
                held_score[pos] = sc;
                held_ref[pos]   = rf;
                held_len[pos]   = ln;
                w.accepted      = 1'b1;
                w.placed_rank   = RANK_W'(pos);
            end
        end
        else
        begin
            w.placed_rank = rk;
            if (rk < LIST_LEN)
            begin
                w.entry_score  = held_score[rk];
                w.entry_ref_id = held_ref[rk];
                w.entry_length = held_len[rk];
            end
        end
        w.filled = RANK_W'(held_count);
        return w;
    endfunction

    function automatic logic [LEN_W-1:0] random_length();
        return LEN_W'({$urandom, $urandom});
    endfunction

    // Holds start high until the word is taken, then keeps it high within a burst.
    task automatic send_word(input logic rq, input logic [SCORE_W-1:0] sc,
                             input logic [REF_W-1:0] rf, input logic [LEN_W-1:0] ln,
                             input logic [RANK_W-1:0] rk);
        list_word_t w;
        int         gap;
        start      <= 1'b1;
        req_type   <= rq;
        score      <= sc;
        ref_id     <= rf;
        seq_length <= ln;
        rank       <= rk;
        do
            @(posedge clk);
        while (busy);
        w = apply_request(rq, sc, rf, ln, rk);
        expected_words.push_back(w);
        if (rq == REQ_OFFER)
        begin
            offers_sent++;
            if (w.accepted)
                offers_entered++;
        end
        else
        begin
            reads_sent++;
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on)
            begin
                if ($urandom_range(0, 3) == 0)
                    gap = $urandom_range(10, 45);
                else
                    gap = $urandom_range(1, 6);
                // junk on the payload while start is low
                start      <= 1'b0;
                req_type   <= 1'($urandom);
                score      <= SCORE_W'($urandom);
                ref_id     <= $urandom;
                seq_length <= random_length();
                rank       <= RANK_W'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic offer(input logic [SCORE_W-1:0] sc, input logic [REF_W-1:0] rf,
                         input logic [LEN_W-1:0] ln);
        send_word(REQ_OFFER, sc, rf, ln, RANK_W'($urandom));
    endtask

    task automatic read_rank(input logic [RANK_W-1:0] rk);
        send_word(REQ_READ, SCORE_W'($urandom), $urandom, random_length(), rk);
    endtask

    task automatic test_reset_reads();
        read_rank(RANK_W'(0));
        read_rank(RANK_W'(LIST_LEN - 1));
        read_rank('1);
    endtask

    task automatic test_fill();
        int fill_scores [LIST_LEN] = '{262143, 0, 65536, 65536, 7, 7, 131072, 131071, 1,
                                       7, 3000, 262143, 42, 65535, 65537, 500, 9};
        for (int i = 0; i < LIST_LEN; i++)
        begin
            if (i == 1)
                offer(SCORE_W'(fill_scores[i]), '1, '1);
            else if (i == 2)
                offer(SCORE_W'(fill_scores[i]), '0, '0);
            else
                offer(SCORE_W'(fill_scores[i]), $urandom, random_length());
        end
    endtask

    task automatic test_full_list();
        logic [SCORE_W-1:0] worst;
        worst = held_score[LIST_LEN-1];
        offer(worst, $urandom, random_length());          // tie with tail: rejected
        offer(worst - 1'b1, $urandom, random_length());   // just under tail: enters
        offer('1, $urandom, random_length());
        read_rank(RANK_W'(LIST_LEN - 1));
        read_rank(RANK_W'(LIST_LEN));
    endtask

    // Offers are mostly aimed near the tail or at existing scores, so that
    // insertions keep landing at every rank.
    task automatic test_random_traffic(input int n_words, input bit with_gaps);
        int                 pick;
        int                 span;
        logic [SCORE_W-1:0] worst;
        logic [SCORE_W-1:0] sc;
        gaps_on = with_gaps;
        for (int n = 0; n < n_words; n++)
        begin
            pick  = $urandom_range(0, 99);
            worst = held_score[LIST_LEN-1];
            if (pick < 40)
            begin
                span = (worst < 4096) ? int'(worst) : 4096;
                sc   = worst - SCORE_W'($urandom_range(0, span));
                offer(sc, $urandom, random_length());
            end
            else if (pick < 55)
            begin
                offer(held_score[$urandom_range(0, LIST_LEN - 1)], $urandom, random_length());
            end
            else if (pick < 65)
            begin
                offer(SCORE_W'($urandom), $urandom, random_length());
            end
            else if (pick < 93)
            begin
                read_rank(RANK_W'($urandom_range(0, LIST_LEN - 1)));
            end
            else
            begin
                read_rank(RANK_W'($urandom_range(LIST_LEN, 31)));
            end
        end
    endtask

    task automatic note_error(input string what, input list_word_t want, input list_word_t got);
        if (mismatch_count < 10)
        begin
            $display("tb: %s at %0t", what, $realtime);
            $display("    expected acc=%0d rank=%0d score=%h ref=%h len=%h filled=%0d",
                     want.accepted, want.placed_rank, want.entry_score, want.entry_ref_id,
                     want.entry_length, want.filled);
            $display("    actual   acc=%0d rank=%0d score=%h ref=%h len=%h filled=%0d",
                     got.accepted, got.placed_rank, got.entry_score, got.entry_ref_id,
                     got.entry_length, got.filled);
        end
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : result_check
        list_word_t got;
        list_word_t want;
        if (rst_n && done)
        begin
            got = '{accepted, placed_rank, entry_score, entry_ref_id, entry_length, filled};
            if (expected_words.size() == 0)
            begin
                note_error("result word with nothing pending", '0, got);
            end
            else
            begin
                want = expected_words.pop_front();
                words_checked++;
                if (got !== want)
                    note_error("result word mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: no progress for %0d cycles, %0d words pending",
                     idle_cycles, expected_words.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        clear_list();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_reads();
        test_fill();
        test_full_list();
        test_random_traffic(700, 1'b1);
        test_random_traffic(300, 1'b0);
        test_random_traffic(400, 1'b1);

        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d result words checked: %0d offers (%0d entered the list), %0d reads",
                 words_checked, offers_sent, offers_entered, reads_sent);
        $display("tb: %0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
